// ===== src/rde_pkg.sv =====
// Shared types, constants and helpers for the radix digit emitter.
package rde_pkg;

    localparam int NUM_W       = 32;
    localparam int SYM_NUM     = 16;
    localparam int SYM_W       = 8;
    localparam int DIG_W       = $clog2(SYM_NUM);
    localparam int CNT_W       = 5;
    localparam int CFG_W       = 64;
    localparam int IDX_W       = 2;
    localparam int STACK_DEPTH = NUM_W;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int DCNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int SLICE_W     = 8;
    localparam int SLICES      = NUM_W / SLICE_W;
    localparam int SLICE_CNT_W = $clog2(SLICES);

    localparam logic [IDX_W-1:0] REG_DIGIT_COUNT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [CNT_W-1:0]         digit_count;
        logic [SYM_NUM*SYM_W-1:0] symbols;
    } cfg_t;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] mag;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_DIGIT
    } back_state_t;

    function automatic logic [SYM_W-1:0] symbol_at(input cfg_t cfg,
                                                   input logic [DIG_W-1:0] idx);
        return cfg.symbols[idx*SYM_W +: SYM_W];
    endfunction

endpackage

// ===== src/rde_front.sv =====
// Front end: input stage, alphabet check, sign split and magnitude.
module rde_front import rde_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [NUM_W-1:0] s_number,
    output logic                    job_valid,
    output job_t                    job,
    input  logic                    job_ready
);

    logic             ok_reg, ok_next;
    logic             stage_valid_reg;
    logic [NUM_W-1:0] stage_num_reg;
    logic             stage_free;
    logic [SYM_W-1:0] sym [SYM_NUM];

    always_comb begin
        for (int i = 0; i < SYM_NUM; i++) begin
            sym[i] = symbol_at(cfg, DIG_W'(i));
        end
        ok_next = (cfg.digit_count >= CNT_W'(2)) && (cfg.digit_count <= CNT_W'(SYM_NUM));
        for (int i = 0; i < SYM_NUM; i++) begin
            if (CNT_W'(i) < cfg.digit_count) begin
                if (sym[i] == CH_PLUS || sym[i] == CH_MINUS) begin
                    ok_next = 1'b0;
                end
                for (int j = i + 1; j < SYM_NUM; j++) begin
                    if (CNT_W'(j) < cfg.digit_count && sym[j] == sym[i]) begin
                        ok_next = 1'b0;
                    end
                end
            end
        end
    end

    // Drop the staged item when the alphabet is invalid.
    assign stage_free = !stage_valid_reg || !ok_reg || job_ready;
    assign s_ready    = stage_free;
    assign job_valid  = stage_valid_reg && ok_reg;
    assign job.neg    = stage_num_reg[NUM_W-1];
    assign job.mag    = stage_num_reg[NUM_W-1] ? (NUM_W'(0) - stage_num_reg) : stage_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg          <= 1'b0;
            stage_valid_reg <= 1'b0;
        end else begin
            ok_reg <= ok_next;
            if (stage_free) begin
                stage_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && stage_free) begin
            stage_num_reg <= $unsigned(s_number);
        end
    end

endmodule

// ===== src/rde_queue.sv =====
// Two-entry job queue between front end and digit engine.
module rde_queue import rde_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ===== src/rde_back.sv =====
// Digit engine: slice-serial division by the base, digit stack, byte emitter.
module rde_back import rde_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             job_valid,
    output logic             job_ready,
    input  job_t             job,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [SYM_W-1:0] m_out_char,
    output logic             m_last
);

    back_state_t            state_reg, state_next;
    logic [NUM_W-1:0]       quot_reg;
    logic [DIG_W-1:0]       rem_reg;
    logic [SLICE_CNT_W-1:0] slice_reg;
    logic                   neg_reg;
    logic [DCNT_W-1:0]      cnt_reg;
    logic [DIG_W-1:0]       stack [STACK_DEPTH];

    logic [SLICE_W-1:0]     top_bits;
    logic [SLICE_W-1:0]     qbits;
    logic [DIG_W-1:0]       div_rem;
    logic [DIG_W:0]         trial;
    logic [NUM_W-1:0]       div_quot;
    logic                   last_slice;
    logic [STACK_AW-1:0]    top_idx;

    // Restoring division over one byte of the dividend per cycle.
    always_comb begin
        top_bits = quot_reg[NUM_W-1 -: SLICE_W];
        div_rem  = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int k = 0; k < SLICE_W; k++) begin
            trial = {div_rem, top_bits[SLICE_W-1-k]};
            if (trial >= cfg.digit_count) begin
                qbits[SLICE_W-1-k] = 1'b1;
                div_rem = DIG_W'(trial - cfg.digit_count);
            end else begin
                div_rem = trial[DIG_W-1:0];
            end
        end
        div_quot = {quot_reg[NUM_W-SLICE_W-1:0], qbits};
    end

    assign last_slice = (slice_reg == SLICE_CNT_W'(SLICES - 1));
    assign top_idx    = STACK_AW'(cnt_reg - DCNT_W'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (last_slice && div_quot == '0) begin
                    state_next = neg_reg ? BK_SIGN : BK_DIGIT;
                end
            end
            BK_SIGN: begin
                if (m_ready) begin
                    state_next = BK_DIGIT;
                end
            end
            BK_DIGIT: begin
                if (m_ready && cnt_reg == DCNT_W'(1)) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        job_ready  = 1'b0;
        m_valid    = 1'b0;
        m_last     = 1'b0;
        m_out_char = symbol_at(cfg, stack[top_idx]);
        unique case (state_reg)
            BK_IDLE: begin
                job_ready = 1'b1;
            end
            BK_DIV: begin
            end
            BK_SIGN: begin
                m_valid    = 1'b1;
                m_out_char = CH_MINUS;
            end
            BK_DIGIT: begin
                m_valid = 1'b1;
                m_last  = (cnt_reg == DCNT_W'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                BK_IDLE: begin
                    if (job_valid) begin
                        cnt_reg <= '0;
                    end
                end
                BK_DIV: begin
                    if (last_slice) begin
                        cnt_reg <= cnt_reg + DCNT_W'(1);
                    end
                end
                BK_SIGN: begin
                end
                BK_DIGIT: begin
                    if (m_ready) begin
                        cnt_reg <= cnt_reg - DCNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_IDLE && job_valid) begin
            quot_reg  <= job.mag;
            rem_reg   <= '0;
            slice_reg <= '0;
            neg_reg   <= job.neg;
        end else if (state_reg == BK_DIV) begin
            quot_reg  <= div_quot;
            slice_reg <= slice_reg + SLICE_CNT_W'(1);
            rem_reg   <= last_slice ? '0 : div_rem;
        end
    end

    // Push digits least significant first; pop them in reverse.
    always_ff @(posedge aclk) begin
        if (state_reg == BK_DIV && last_slice) begin
            stack[cnt_reg[STACK_AW-1:0]] <= div_rem;
        end
    end

endmodule

// ===== src/radix_digit_emitter.sv =====
// Radix digit emitter: signed integer to text in a configurable base.
//
// Input channel s_valid/s_ready carries one signed 32-bit s_number per
// transfer. Output channel m_valid/m_ready carries one byte per transfer on
// m_out_char; m_last marks the final byte of a number. A negative number
// starts with '-', then its magnitude follows most significant digit first.
// If the alphabet (digit_count symbols from symbols_low/high) has fewer
// than two or more than sixteen symbols, contains '+' or '-', or repeats a
// symbol, items are accepted and dropped without output.
// Configuration is a plain write port (cfg_wr_en, cfg_wr_index,
// cfg_wr_data); write it only while no item is in flight.
// The shared divider resolves one byte of the dividend per cycle, one
// digit per pass over all four bytes. Base 16 needs at most 8 digits,
// base 2 up to 32. A two-entry queue lets new numbers enter while the
// digit engine works or waits. A stalled receiver holds the current byte;
// the queue then fills and s_ready drops. Reset clears all configuration
// to zero (alphabet invalid) and empties the pipeline.
module radix_digit_emitter import rde_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [NUM_W-1:0] s_number,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SYM_W-1:0]        m_out_char,
    output logic                    m_last,
    input  logic                    cfg_wr_en,
    input  logic [IDX_W-1:0]        cfg_wr_index,
    input  logic [CFG_W-1:0]        cfg_wr_data
);

    logic [CNT_W-1:0] digit_count_reg;
    logic [CFG_W-1:0] symbols_low_reg;
    logic [CFG_W-1:0] symbols_high_reg;
    cfg_t             cfg;

    logic fr_valid, fr_ready;
    job_t fr_job;
    logic q_valid, q_ready;
    job_t q_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg  <= '0;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_DIGIT_COUNT:  digit_count_reg  <= cfg_wr_data[CNT_W-1:0];
                REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_wr_data;
                REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.digit_count = digit_count_reg;
    assign cfg.symbols     = {symbols_high_reg, symbols_low_reg};

    rde_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_number  (s_number),
        .job_valid (fr_valid),
        .job       (fr_job),
        .job_ready (fr_ready)
    );

    rde_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_job    (fr_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    rde_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .job_valid  (q_valid),
        .job_ready  (q_ready),
        .job        (q_job),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for radix_digit_emitter: number-to-text conversion in a programmable base.
module testbench;
    import rde_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 400;   // two queued numbers of up to 32 digits and a sign each
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned RANDOM_SETS   = 9;
    localparam int unsigned NUMS_PER_SET  = 14;

    typedef struct packed {
        logic [SYM_W-1:0] ch;
        logic             last;
    } text_byte_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [NUM_W-1:0] s_number = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [SYM_W-1:0]        m_out_char;
    logic                    m_last;
    logic                    cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]        cfg_wr_index = REG_DIGIT_COUNT;
    logic [CFG_W-1:0]        cfg_wr_data = '0;

    // Shadow copy of the alphabet registers
    logic [CNT_W-1:0] alpha_count = '0;
    logic [CFG_W-1:0] alpha_low = '0;
    logic [CFG_W-1:0] alpha_high = '0;

    text_byte_t  pending_text[$];
    text_byte_t  got_byte;
    int unsigned s_idle_pct = 15;
    int unsigned r_idle_pct = 63;
    int unsigned errors = 0;
    int unsigned numbers_sent = 0;
    int unsigned numbers_with_text = 0;
    int unsigned bytes_checked = 0;
    int unsigned alphabets_loaded = 0;
    int unsigned cycle_count = 0;

    radix_digit_emitter u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_number    (s_number),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last      (m_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= r_idle_pct);
    end

    // ---------------- text predictor ----------------

    function automatic logic [SYM_W-1:0] glyph(input int unsigned digit);
        logic [2*CFG_W-1:0] table_bits;
        table_bits = {alpha_high, alpha_low};
        return table_bits[digit*SYM_W +: SYM_W];
    endfunction

    function automatic bit alphabet_usable();
        int unsigned n;
        n = alpha_count;
        if (n < 2 || n > SYM_NUM)
            return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (glyph(i) == CH_PLUS || glyph(i) == CH_MINUS)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (glyph(j) == glyph(i))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_text(input logic signed [NUM_W-1:0] number);
        logic [NUM_W-1:0] mag;
        logic [SYM_W-1:0] digits[$];
        int unsigned      base;
        text_byte_t       entry;
        if (!alphabet_usable())
            return;
        base = alpha_count;
        numbers_with_text++;
        if (number[NUM_W-1]) begin
            mag = 32'd0 - number;
            entry.ch = CH_MINUS;
            entry.last = 1'b0;
            pending_text.push_back(entry);
        end else begin
            mag = number;
        end
        do begin
            digits.push_front(glyph(mag % base));
            mag = mag / base;
        end while (mag != 0);
        foreach (digits[i]) begin
            entry.ch = digits[i];
            entry.last = (i == digits.size() - 1);
            pending_text.push_back(entry);
        end
    endfunction

    // ---------------- result checker ----------------

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_text.size() == 0) begin
                $display("%0t: unexpected byte %02h (last %0b), expected nothing",
                         $time, m_out_char, m_last);
                errors++;
            end else begin
                got_byte = pending_text.pop_front();
                bytes_checked++;
                if (m_out_char !== got_byte.ch) begin
                    $display("%0t: out_char mismatch, expected %02h, actual %02h",
                             $time, got_byte.ch, m_out_char);
                    errors++;
                end
                if (m_last !== got_byte.last) begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, got_byte.last, m_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d bytes still expected",
                 cycle_count, pending_text.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------- drivers ----------------

    task automatic send_number(input logic signed [NUM_W-1:0] number);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_number <= number;
        // sample s_ready as it stood at the edge, before the block updates
        @(posedge aclk iff s_ready);
        numbers_sent++;
        predict_text(number);
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_text.size() != 0);
    endtask

    // Items under a bad alphabet leave no trace, so give the engine time to finish.
    task automatic quiesce();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (index)
            REG_DIGIT_COUNT:  alpha_count = data[CNT_W-1:0];
            REG_SYMBOLS_LOW:  alpha_low = data;
            REG_SYMBOLS_HIGH: alpha_high = data;
            default: ;
        endcase
    endtask

    task automatic set_alphabet(input logic [CFG_W-1:0] count_word,
                                input logic [SYM_NUM*SYM_W-1:0] syms);
        quiesce();
        if ($urandom_range(1))
            write_reg(REG_UNUSED, {$urandom, $urandom});
        write_reg(REG_SYMBOLS_HIGH, syms[2*CFG_W-1:CFG_W]);
        write_reg(REG_DIGIT_COUNT, count_word);
        write_reg(REG_SYMBOLS_LOW, syms[CFG_W-1:0]);
        alphabets_loaded++;
    endtask

    // ---------------- random content ----------------

    // Distinct symbols free of sign characters in the first cnt slots; the
    // unused slots get junk, signs or repeats, which the block must ignore.
    function automatic logic [SYM_NUM*SYM_W-1:0] random_symbols(input int unsigned cnt);
        logic [SYM_NUM*SYM_W-1:0] syms;
        logic [255:0]             taken;
        logic [SYM_W-1:0]         b;
        taken = '0;
        syms = '0;
        for (int i = 0; i < SYM_NUM; i++) begin
            if (i < cnt) begin
                do b = SYM_W'($urandom_range(255));
                while (b == CH_PLUS || b == CH_MINUS || taken[b]);
                taken[b] = 1'b1;
            end else begin
                case ($urandom_range(2))
                    0: b = CH_MINUS;
                    1: b = syms[SYM_W-1:0];
                    default: b = SYM_W'($urandom_range(255));
                endcase
            end
            syms[i*SYM_W +: SYM_W] = b;
        end
        return syms;
    endfunction

    function automatic logic [CFG_W-1:0] count_word(input int unsigned cnt);
        logic [CFG_W-1:0] w;
        w = {$urandom, $urandom};
        w[CNT_W-1:0] = CNT_W'(cnt);
        return w;
    endfunction

    function automatic logic signed [NUM_W-1:0] random_number(input int unsigned base);
        logic [63:0]      p;
        logic [NUM_W-1:0] v;
        int unsigned      steps;
        p = 1;
        case ($urandom_range(4))
            0: v = $urandom_range(0, 3 * base);
            1: begin
                // land near a power of the base, where the digit count changes
                steps = $urandom_range(1, 31);
                repeat (steps)
                    if (p * base <= 64'h8000_0000)
                        p = p * base;
                v = p[NUM_W-1:0] - 32'd1 + $urandom_range(0, 2);
            end
            2: begin
                case ($urandom_range(3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: v = $urandom;
        endcase
        if ($urandom_range(1))
            v = 32'd0 - v;
        return v;
    endfunction

    // ---------------- tests ----------------

    task automatic test_reset_alphabet();
        // reset leaves digit_count at zero: numbers are swallowed
        send_number(32'sd7);
        send_number(-32'sd7);
    endtask

    task automatic test_decimal();
        // garbage above the 5-bit count field is dropped
        set_alphabet(64'hFFFF_FFFF_FFFF_FFEA,
                     {64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130});
        send_number(32'sd0);
        send_number(32'sd1);
        send_number(-32'sd1);
        send_number(32'sh7FFF_FFFF);
        send_number(32'sh8000_0000);
        send_number(32'sd9);
        send_number(-32'sd10);
        wait_results();
        write_reg(REG_UNUSED, 64'h0000_0000_0000_0002);
        send_number(32'sd12345);
    endtask

    task automatic test_binary();
        // signs and repeats beyond the count are ignored
        set_alphabet(64'd2, {64'h2B2B_2B2B_2B2B_2B2B, 64'h2B2D_3030_2D2B_3130});
        send_number(32'sh8000_0000);
        send_number(32'sh7FFF_FFFF);
        send_number(32'sh5555_5555);
        send_number(32'sd0);
    endtask

    task automatic test_hex_odd_symbols();
        // symbol 0 is a zero byte, symbol 1 is 0xFF
        set_alphabet(64'd16, {64'h4E4D_4C4B_4A49_4847, 64'h4645_4443_4241_FF00});
        send_number(32'sd0);
        send_number(-32'sd1);
        send_number(32'sh8000_0000);
        send_number(32'sh0123_4567);
    endtask

    task automatic test_bad_alphabets();
        logic [SYM_NUM*SYM_W-1:0] hex_syms;
        hex_syms = {64'h4E4D_4C4B_4A49_4847, 64'h4645_4443_4241_FF00};
        set_alphabet(64'd1, hex_syms);
        send_number(32'sd5);
        set_alphabet(64'd17, hex_syms);
        send_number(32'sd100);
        set_alphabet(64'd31, hex_syms);
        send_number(-32'sd100);
        set_alphabet(64'd3, {64'd0, 64'h0000_0000_0031_2B30});
        send_number(32'sd2);
        set_alphabet(64'd16, {64'h2D4D_4C4B_4A49_4847, 64'h4645_4443_4241_FF00});
        send_number(-32'sd2);
        set_alphabet(64'd16, {64'h004D_4C4B_4A49_4847, 64'h4645_4443_4241_FF00});
        send_number(32'sd77);
    endtask

    task automatic load_bad_alphabet();
        logic [SYM_NUM*SYM_W-1:0] syms;
        int unsigned              cnt;
        int unsigned              i;
        int unsigned              j;
        case ($urandom_range(3))
            0: begin
                cnt = $urandom_range(0, 1);
                syms = random_symbols(SYM_NUM);
            end
            1: begin
                cnt = $urandom_range(SYM_NUM + 1, 31);
                syms = random_symbols(SYM_NUM);
            end
            2: begin
                cnt = $urandom_range(2, SYM_NUM);
                syms = random_symbols(cnt);
                i = $urandom_range(0, cnt - 1);
                syms[i*SYM_W +: SYM_W] = $urandom_range(1) ? CH_PLUS : CH_MINUS;
            end
            default: begin
                cnt = $urandom_range(2, SYM_NUM);
                syms = random_symbols(cnt);
                j = $urandom_range(1, cnt - 1);
                i = $urandom_range(0, j - 1);
                syms[j*SYM_W +: SYM_W] = syms[i*SYM_W +: SYM_W];
            end
        endcase
        set_alphabet(count_word(cnt), syms);
    endtask

    task automatic test_random_numbers();
        int unsigned cnt;
        for (int set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
            if (set_idx < 3) begin
                s_idle_pct = 15;
                r_idle_pct = 63;
            end else if (set_idx < 6) begin
                s_idle_pct = 63;
                r_idle_pct = 15;
            end else begin
                s_idle_pct = 0;
                r_idle_pct = 0;
            end
            case ($urandom_range(3))
                0: cnt = 2;
                1: cnt = SYM_NUM;
                default: cnt = $urandom_range(2, SYM_NUM);
            endcase
            set_alphabet(count_word(cnt), random_symbols(cnt));
            for (int k = 0; k < NUMS_PER_SET; k++) begin
                // hold the sender until the block has fully drained
                if (k == NUMS_PER_SET / 2 && set_idx % 2 == 0)
                    wait_results();
                send_number(random_number(cnt));
            end
            if (set_idx == 4) begin
                repeat (3) begin
                    load_bad_alphabet();
                    send_number($urandom);
                    send_number(random_number(10));
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_alphabet();
        test_decimal();
        test_binary();
        test_hex_odd_symbols();
        test_bad_alphabets();
        test_random_numbers();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Converted %0d numbers (%0d with a usable alphabet) over %0d alphabets,",
                 numbers_sent, numbers_with_text, alphabets_loaded);
        $display("checked %0d output bytes, %0d errors.", bytes_checked, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== radix_digit_emitter.f =====
src/rde_pkg.sv
src/rde_front.sv
src/rde_queue.sv
src/rde_back.sv
src/radix_digit_emitter.sv
verif/testbench.sv
